// ===== hw/rtl/brlr_pkg.sv =====
package brlr_pkg;

    // request kinds carried on the input tuser bit
    typedef enum logic
    {
        ACT_LOAD    = 1'b0,
        ACT_ADVANCE = 1'b1
    } action_t;

    // control word of one request held in a pipeline stage
    typedef struct packed
    {
        logic    valid;
        action_t action;
    } stage_ctl_t;

endpackage

// ===== hw/rtl/bresenham_line_rasterizer_unit.sv =====
// Bresenham line rasterizer for all octants. A load request (tuser = 0) gives two
// endpoints; the block picks the axis with the larger span as the major axis (x on a
// tie), orders the endpoints so the major coordinate rises, and arms the error terms.
// Each advance request (tuser = 1) returns the next pixel from the low-major end, with
// tlast on the final one; an advance with no line armed, and every load, returns an
// all-zero result with tuser low. Exactly one result goes out per request, in order.
// Rate: one request per clock while the output is not stalled; each request is held
// in the input register, then its result in the result register. The rate is set by
// the line-state update (adds and compares per pixel) between those two registers;
// while a result waits at the output, the input register still takes one request.
module bresenham_line_rasterizer_unit
    import brlr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // x_start, y_start, x_end, y_end from bit 0 up, zero filled to whole bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // action
    input  logic [0:0]                               s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // pixel_x, pixel_y from bit 0 up, zero filled to whole bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
    // pixel_valid
    output logic [0:0]                               m_axis_tuser,
    // line_last
    output logic                                     m_axis_tlast
);

    localparam int OUT_BITS = ((2*COORD_BITS+7)/8)*8;

    stage_ctl_t              setup_ctl;
    logic                    in_take;
    logic                    out_free;
    logic                    item_move;
    action_t                 in_action;

    logic [COORD_BITS-1:0]   major_start;
    logic [COORD_BITS-1:0]   minor_start;
    logic [COORD_BITS-1:0]   major_end;
    logic [COORD_BITS+2:0]   err_start;
    logic [COORD_BITS:0]     inc_keep;
    logic [COORD_BITS+1:0]   inc_step;
    logic                    minor_down;
    logic                    axes_swapped;

    logic [COORD_BITS-1:0]   pixel_x;
    logic [COORD_BITS-1:0]   pixel_y;
    logic                    pixel_valid;
    logic                    line_last;

    // the result slot frees when empty or being drained this cycle
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign item_move     = setup_ctl.valid && out_free;
    assign s_axis_tready = !setup_ctl.valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign in_action     = action_t'(s_axis_tuser[0]);

    // input register and endpoint ordering
    brlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_take      (in_take),
        .in_action    (in_action),
        .in_x_start   (s_axis_tdata[COORD_BITS-1:0]),
        .in_y_start   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_x_end     (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .in_y_end     (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .item_move    (item_move),
        .ctl          (setup_ctl),
        .major_start  (major_start),
        .minor_start  (minor_start),
        .major_end    (major_end),
        .err_start    (err_start),
        .inc_keep     (inc_keep),
        .inc_step     (inc_step),
        .minor_down   (minor_down),
        .axes_swapped (axes_swapped)
    );

    // line state stepping and result register
    brlr_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_move    (item_move),
        .action       (setup_ctl.action),
        .major_start  (major_start),
        .minor_start  (minor_start),
        .major_end    (major_end),
        .err_start    (err_start),
        .inc_keep     (inc_keep),
        .inc_step     (inc_step),
        .minor_down   (minor_down),
        .axes_swapped (axes_swapped),
        .out_take     (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_valid  (pixel_valid),
        .line_last    (line_last)
    );

    assign m_axis_tdata = OUT_BITS'({pixel_y, pixel_x});
    assign m_axis_tuser = pixel_valid;
    assign m_axis_tlast = line_last;

endmodule

// ===== hw/rtl/brlr_setup.sv =====
module brlr_setup
    import brlr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_take,
    input  action_t                 in_action,
    input  logic [COORD_BITS-1:0]   in_x_start,
    input  logic [COORD_BITS-1:0]   in_y_start,
    input  logic [COORD_BITS-1:0]   in_x_end,
    input  logic [COORD_BITS-1:0]   in_y_end,
    input  logic                    item_move,
    output stage_ctl_t              ctl,
    output logic [COORD_BITS-1:0]   major_start,
    output logic [COORD_BITS-1:0]   minor_start,
    output logic [COORD_BITS-1:0]   major_end,
    output logic [COORD_BITS+2:0]   err_start,
    output logic [COORD_BITS:0]     inc_keep,
    output logic [COORD_BITS+1:0]   inc_step,
    output logic                    minor_down,
    output logic                    axes_swapped
);

    stage_ctl_t              ctl_reg;
    stage_ctl_t              ctl_next;
    logic [COORD_BITS-1:0]   xs_reg;
    logic [COORD_BITS-1:0]   ys_reg;
    logic [COORD_BITS-1:0]   xe_reg;
    logic [COORD_BITS-1:0]   ye_reg;

    logic [COORD_BITS:0]     dx;
    logic [COORD_BITS:0]     dy;
    logic [COORD_BITS:0]     dx_neg;
    logic [COORD_BITS:0]     dy_neg;
    logic [COORD_BITS-1:0]   adx;
    logic [COORD_BITS-1:0]   ady;
    logic [COORD_BITS-1:0]   dmaj;
    logic [COORD_BITS-1:0]   dmin;
    logic [COORD_BITS:0]     maj_raw;
    logic [COORD_BITS:0]     min_raw;
    logic                    reversed;

    always_comb
    begin
        ctl_next = ctl_reg;
        if (in_take)
        begin
            ctl_next.valid  = 1'b1;
            ctl_next.action = in_action;
        end
        else if (item_move)
        begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, action: ACT_LOAD};
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            xs_reg <= in_x_start;
            ys_reg <= in_y_start;
            xe_reg <= in_x_end;
            ye_reg <= in_y_end;
        end
    end

    // signed spans and their magnitudes, both axes side by side
    always_comb
    begin
        dx     = {1'b0, xe_reg} - {1'b0, xs_reg};
        dy     = {1'b0, ye_reg} - {1'b0, ys_reg};
        dx_neg = ~dx + 1'b1;
        dy_neg = ~dy + 1'b1;
        adx    = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady    = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

        // equal spans keep x as the major axis
        axes_swapped = (adx < ady);
        maj_raw      = axes_swapped ? dy : dx;
        min_raw      = axes_swapped ? dx : dy;
        dmaj         = axes_swapped ? ady : adx;
        dmin         = axes_swapped ? adx : ady;
        reversed     = maj_raw[COORD_BITS];

        // ordering the endpoints flips the sign of the minor span
        minor_down = (min_raw != '0) && (min_raw[COORD_BITS] ^ reversed);

        if (reversed)
        begin
            major_start = axes_swapped ? ye_reg : xe_reg;
            minor_start = axes_swapped ? xe_reg : ye_reg;
            major_end   = axes_swapped ? ys_reg : xs_reg;
        end
        else
        begin
            major_start = axes_swapped ? ys_reg : xs_reg;
            minor_start = axes_swapped ? xs_reg : ys_reg;
            major_end   = axes_swapped ? ye_reg : xe_reg;
        end

        inc_keep  = {dmin, 1'b0};
        inc_step  = {1'b0, dmin, 1'b0} - {1'b0, dmaj, 1'b0};
        err_start = {2'b00, dmin, 1'b0} - {3'b000, dmaj};
    end

    assign ctl = ctl_reg;

endmodule

// ===== hw/rtl/brlr_walk.sv =====
module brlr_walk
    import brlr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_move,
    input  action_t                 action,
    input  logic [COORD_BITS-1:0]   major_start,
    input  logic [COORD_BITS-1:0]   minor_start,
    input  logic [COORD_BITS-1:0]   major_end,
    input  logic [COORD_BITS+2:0]   err_start,
    input  logic [COORD_BITS:0]     inc_keep,
    input  logic [COORD_BITS+1:0]   inc_step,
    input  logic                    minor_down,
    input  logic                    axes_swapped,
    input  logic                    out_take,
    output logic                    out_valid,
    output logic [COORD_BITS-1:0]   pixel_x,
    output logic [COORD_BITS-1:0]   pixel_y,
    output logic                    pixel_valid,
    output logic                    line_last
);

    localparam int ERR_BITS = COORD_BITS + 3;

    // line state
    logic                    line_active_reg;
    logic                    line_active_next;
    logic [COORD_BITS-1:0]   major_pos_reg;
    logic [COORD_BITS-1:0]   major_pos_next;
    logic [COORD_BITS-1:0]   minor_pos_reg;
    logic [COORD_BITS-1:0]   minor_pos_next;
    logic [COORD_BITS-1:0]   major_stop_reg;
    logic [ERR_BITS-1:0]     error_acc_reg;
    logic [ERR_BITS-1:0]     error_acc_next;
    logic [COORD_BITS:0]     err_inc_keep_reg;
    logic [COORD_BITS+1:0]   err_inc_step_reg;
    logic                    minor_down_reg;
    logic                    axes_swapped_reg;

    // result register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [COORD_BITS-1:0]   pixel_x_reg;
    logic [COORD_BITS-1:0]   pixel_x_next;
    logic [COORD_BITS-1:0]   pixel_y_reg;
    logic [COORD_BITS-1:0]   pixel_y_next;
    logic                    pixel_valid_reg;
    logic                    pixel_valid_next;
    logic                    line_last_reg;
    logic                    line_last_next;

    logic                    do_load;
    logic                    do_step;
    logic                    err_not_pos;

    assign do_load     = item_move && (action == ACT_LOAD);
    assign do_step     = item_move && (action == ACT_ADVANCE) && line_active_reg;
    assign err_not_pos = error_acc_reg[ERR_BITS-1] || (error_acc_reg == '0);

    always_comb
    begin
        line_active_next = line_active_reg;
        major_pos_next   = major_pos_reg;
        minor_pos_next   = minor_pos_reg;
        error_acc_next   = error_acc_reg;
        pixel_x_next     = '0;
        pixel_y_next     = '0;
        pixel_valid_next = 1'b0;
        line_last_next   = 1'b0;

        if (do_load)
        begin
            line_active_next = 1'b1;
            major_pos_next   = major_start;
            minor_pos_next   = minor_start;
            error_acc_next   = err_start;
        end
        else if (do_step)
        begin
            pixel_valid_next = 1'b1;
            pixel_x_next     = axes_swapped_reg ? minor_pos_reg : major_pos_reg;
            pixel_y_next     = axes_swapped_reg ? major_pos_reg : minor_pos_reg;
            if (major_pos_reg == major_stop_reg)
            begin
                line_last_next   = 1'b1;
                line_active_next = 1'b0;
            end
            else
            begin
                if (err_not_pos)
                begin
                    error_acc_next = error_acc_reg + {2'b00, err_inc_keep_reg};
                end
                else
                begin
                    error_acc_next = error_acc_reg
                                   + {err_inc_step_reg[COORD_BITS+1], err_inc_step_reg};
                    minor_pos_next = minor_down_reg ? minor_pos_reg - 1'b1
                                                    : minor_pos_reg + 1'b1;
                end
                major_pos_next = major_pos_reg + 1'b1;
            end
        end

        if (item_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            line_active_reg <= line_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        major_pos_reg <= major_pos_next;
        minor_pos_reg <= minor_pos_next;
        error_acc_reg <= error_acc_next;
        if (do_load)
        begin
            major_stop_reg   <= major_end;
            err_inc_keep_reg <= inc_keep;
            err_inc_step_reg <= inc_step;
            minor_down_reg   <= minor_down;
            axes_swapped_reg <= axes_swapped;
        end
        if (item_move)
        begin
            pixel_x_reg     <= pixel_x_next;
            pixel_y_reg     <= pixel_y_next;
            pixel_valid_reg <= pixel_valid_next;
            line_last_reg   <= line_last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_valid = pixel_valid_reg;
    assign line_last   = line_last_reg;

endmodule

// ===== hw/rtl/brlr_checker.sv =====
module brlr_checker
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    input  logic                                     s_axis_tready,
    input  logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
    input  logic [0:0]                               m_axis_tuser,
    input  logic                                     m_axis_tlast
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

    // the final pixel flag only rides on a real pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("line_last without pixel_valid");

    // loads and idle advances give an all-zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tlast)
    else $error("non-pixel result carries data");

    // a fresh result follows an accepted request that has passed the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching request");

endmodule

bind bresenham_line_rasterizer_unit brlr_checker #(.COORD_BITS(COORD_BITS)) u_brlr_checker (.*);

// ===== tb/bresenham_line_rasterizer_unit_tb.sv =====
`timescale 1ns / 1ps

module bresenham_line_rasterizer_unit_tb;
    import brlr_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    // cycles with no request moving on either side before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // a short hold-off after the queue drains catches any stray result
    localparam int TAIL_CYCLES = 12;

    typedef struct packed
    {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  valid;
        logic                  last;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // line state kept by the predictor
    logic [COORD_BITS-1:0] major_pos;
    logic [COORD_BITS-1:0] minor_pos;
    logic [COORD_BITS-1:0] major_stop;
    logic signed [14:0]    err_acc;
    logic [13:0]           err_keep;
    logic signed [14:0]    err_step;
    logic                  minor_down;
    logic                  axes_swapped;
    logic                  line_active;

    pixel_t pixel_queue[$];
    int     mismatch_count;
    int     sent_count;
    int     hang_cycles;
    logic   idling_on;

    bresenham_line_rasterizer_unit #(.COORD_BITS(COORD_BITS)) uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // apply one accepted request to the predicted line state and queue its pixel
    task automatic rasterize_step(input action_t act, input logic [47:0] coords);
        int     xs;
        int     ys;
        int     xe;
        int     ye;
        int     ma0;
        int     mi0;
        int     ma1;
        int     mi1;
        int     t;
        int     dmaj;
        int     dmin;
        pixel_t pix;
        begin
            pix = '0;
            if (act == ACT_LOAD)
            begin
                xs = int'(coords[11:0]);
                ys = int'(coords[23:12]);
                xe = int'(coords[35:24]);
                ye = int'(coords[47:36]);
                // steep lines trade x and y; equal spans keep x as the major axis
                axes_swapped = ((xe > xs) ? xe - xs : xs - xe)
                             < ((ye > ys) ? ye - ys : ys - ye);
                if (axes_swapped)
                begin
                    ma0 = ys; mi0 = xs; ma1 = ye; mi1 = xe;
                end
                else
                begin
                    ma0 = xs; mi0 = ys; ma1 = xe; mi1 = ye;
                end
                // walk from the low-major end
                if (ma1 < ma0)
                begin
                    t = ma0; ma0 = ma1; ma1 = t;
                    t = mi0; mi0 = mi1; mi1 = t;
                end
                dmaj       = ma1 - ma0;
                dmin       = mi1 - mi0;
                minor_down = dmin < 0;
                if (minor_down)
                    dmin = -dmin;
                err_keep    = 14'(2 * dmin);
                err_step    = 15'(2 * (dmin - dmaj));
                err_acc     = 15'(2 * dmin - dmaj);
                major_pos   = COORD_BITS'(ma0);
                minor_pos   = COORD_BITS'(mi0);
                major_stop  = COORD_BITS'(ma1);
                line_active = 1'b1;
            end
            else if (line_active)
            begin
                pix.valid = 1'b1;
                pix.px    = axes_swapped ? minor_pos : major_pos;
                pix.py    = axes_swapped ? major_pos : minor_pos;
                if (major_pos == major_stop)
                begin
                    pix.last    = 1'b1;
                    line_active = 1'b0;
                end
                else
                begin
                    if (err_acc <= 0)
                        err_acc = err_acc + $signed({1'b0, err_keep});
                    else
                    begin
                        minor_pos = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
                        err_acc   = err_acc + err_step;
                    end
                    major_pos = major_pos + 1'b1;
                end
            end
            pixel_queue.push_back(pix);
        end
    endtask

    // drive one request, idling at random first, and hold it until the block takes it
    task automatic send_request(input action_t act, input logic [47:0] coords);
        begin
            @(negedge clk);
            while (idling_on && $urandom_range(0, 99) < 27)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= act;
            s_axis_tdata  <= coords;
            do
                @(posedge clk);
            while (!s_axis_tready);
            rasterize_step(act, coords);
            sent_count++;
        end
    endtask

    // load a line and advance through it; extra > 0 runs past the end, < 0 cuts it short
    task automatic draw_line(input int xs, input int ys, input int xe, input int ye,
                             input int extra);
        int dx;
        int dy;
        int steps;
        begin
            dx    = (xe > xs) ? xe - xs : xs - xe;
            dy    = (ye > ys) ? ye - ys : ys - ye;
            steps = ((dx > dy) ? dx : dy) + 1 + extra;
            send_request(ACT_LOAD, {ye[11:0], xe[11:0], ys[11:0], xs[11:0]});
            repeat (steps)
                send_request(ACT_ADVANCE, 48'({$urandom, $urandom}));
        end
    endtask

    // endpoint near a base coordinate, reflected back when it falls off the grid
    function automatic int near_coord(input int base, input int span);
        int c;
        begin
            c = base + $urandom_range(0, 2 * span) - span;
            if (c < 0 || c > COORD_MAX)
                c = 2 * base - c;
            return c;
        end
    endfunction

    // idle advance, degenerate line, equal spans, steep reversed line, reload mid-line
    task automatic test_special_cases();
        begin
            send_request(ACT_ADVANCE, 48'hFFFF_FFFF_FFFF);
            draw_line(0, 0, 0, 0, 1);
            draw_line(10, 10, 13, 7, 0);
            draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 5, -3);
            draw_line(COORD_MAX, 0, COORD_MAX - 5, 1, 1);
        end
    endtask

    // lines across the full coordinate range, walked only part way
    task automatic test_full_span();
        begin
            draw_line(COORD_MAX, 0, 0, COORD_MAX, -4000);
            draw_line(1, COORD_MAX, 0, 0, -4000);
        end
    endtask

    // mostly complete short lines, some long, some cut short, plus stray requests
    task automatic test_random_lines(input int n_items);
        int first;
        int xs;
        int ys;
        int span;
        int extra;
        begin
            first = sent_count;
            while (sent_count - first < n_items)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_request(ACT_LOAD, 48'({$urandom, $urandom}));
                    repeat ($urandom_range(0, 3))
                        send_request(ACT_ADVANCE, 48'({$urandom, $urandom}));
                    if ($urandom_range(0, 1) == 0)
                        send_request(ACT_ADVANCE, '0);
                end
                else
                begin
                    span  = ($urandom_range(0, 15) == 0) ? 120 : 12;
                    xs    = $urandom_range(0, COORD_MAX);
                    ys    = $urandom_range(0, COORD_MAX);
                    extra = ($urandom_range(0, 9) == 0) ? -$urandom_range(1, 8)
                                                         : $urandom_range(0, 2);
                    draw_line(xs, ys, near_coord(xs, span), near_coord(ys, span), extra);
                end
            end
        end
    endtask

    // back-to-back traffic on both sides
    task automatic test_no_idling();
        begin
            idling_on = 1'b0;
            test_random_lines(150);
            idling_on = 1'b1;
        end
    endtask

    // sender holds off until every queued pixel has been returned
    task automatic test_drain_pause();
        begin
            draw_line(100, 200, 108, 195, 0);
            send_request(ACT_LOAD, {12'd40, 12'd30, 12'd20, 12'd10});
            send_request(ACT_ADVANCE, '0);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            wait (pixel_queue.size() == 0);
            repeat (3)
                send_request(ACT_ADVANCE, '0);
            draw_line(500, 500, 497, 510, 1);
        end
    endtask

    // receiver stalls at random while idling is on
    always @(negedge clk)
    begin
        if (idling_on && $urandom_range(0, 99) < 27)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    // compare every returned pixel with the oldest prediction
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_queue.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none actual x=%0d y=%0d %s",
                         $time, m_axis_tdata[11:0], m_axis_tdata[23:12],
                         $sformatf("valid=%0d last=%0d", m_axis_tuser[0], m_axis_tlast));
            end
            else
            begin
                want = pixel_queue.pop_front();
                if (m_axis_tdata[11:0] !== want.px)
                begin
                    mismatch_count++;
                    $display("%0t: pixel_x expected %0d actual %0d",
                             $time, want.px, m_axis_tdata[11:0]);
                end
                if (m_axis_tdata[23:12] !== want.py)
                begin
                    mismatch_count++;
                    $display("%0t: pixel_y expected %0d actual %0d",
                             $time, want.py, m_axis_tdata[23:12]);
                end
                if (m_axis_tuser[0] !== want.valid)
                begin
                    mismatch_count++;
                    $display("%0t: pixel_valid expected %0d actual %0d",
                             $time, want.valid, m_axis_tuser[0]);
                end
                if (m_axis_tlast !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: line_last expected %0d actual %0d",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    // hang detection: nothing moving on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            hang_cycles = 0;
        else
            hang_cycles++;
        if (hang_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_LOAD;
        m_axis_tready  = 1'b0;
        idling_on      = 1'b1;
        mismatch_count = 0;
        sent_count     = 0;
        hang_cycles    = 0;
        major_pos      = '0;
        minor_pos      = '0;
        major_stop     = '0;
        err_acc        = '0;
        err_keep       = '0;
        err_step       = '0;
        minor_down     = 1'b0;
        axes_swapped   = 1'b0;
        line_active    = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_special_cases();
        test_full_span();
        test_random_lines(350);
        test_no_idling();
        test_drain_pause();
        test_random_lines(300);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pixel_queue.size() == 0);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pixel_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
